### rtl/tmfr_pkg.sv
// Shared constants, types and state codes of the trimmed-mean frame rate meter.
`timescale 1ns / 1ps

package tmfr_pkg;

  // Sizes of the window, the trim and the rate ring.
  localparam int WINDOW_LEN     = 11;
  localparam int TRIM_EACH_SIDE = 2;
  localparam int RATE_AVG_LEN   = 3;

  // Field widths fixed by the interface.
  localparam int PERIOD_W = 24;
  localparam int RATE_W   = 20;

  // Derived widths.
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int SCAN_W     = $clog2(WINDOW_LEN);
  localparam int SUM_W      = PERIOD_W + $clog2(WINDOW_LEN);
  localparam int RATE_NUM_W = RATE_W + CNT_W;
  localparam int DIV_W      = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int SLOT_W     = (RATE_AVG_LEN > 1) ? $clog2(RATE_AVG_LEN) : 1;
  localparam int RING_SUM_W = RATE_W + $clog2(RATE_AVG_LEN);

  // Division of the ring total by RATE_AVG_LEN as a multiply by a rounded-up
  // reciprocal; the shift is large enough that the result is exact for every
  // possible ring total.
  localparam int AVG_SHIFT = RING_SUM_W + $clog2(RATE_AVG_LEN);
  localparam int AVG_MUL_W = AVG_SHIFT + 1;
  localparam int PROD_W    = RING_SUM_W + AVG_MUL_W;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL =
      AVG_MUL_W'(((longint'(1) << AVG_SHIFT) + RATE_AVG_LEN - 1) / RATE_AVG_LEN);

  // Saturation value of the per-frame rate.
  localparam logic [RATE_W-1:0] RATE_CAP = RATE_W'(1000000);

  typedef logic [PERIOD_W-1:0] period_t;

  // Control from the sequencer to the statistics unit.
  typedef struct packed {
    logic clr;
    logic take;
  } stats_ctrl_t;

  // Running statistics of one window scan.
  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] lo_sum;
    logic [SUM_W-1:0] hi_sum;
  } stats_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_LAUNCH,
    S_WAIT,
    S_AVG,
    S_OUT
  } state_t;

endpackage

### rtl/tmfr_cell.sv
// One window cell: holds a frame period and takes its neighbor's value when enabled.
`timescale 1ns / 1ps

module tmfr_cell import tmfr_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  period_t d,
  output period_t q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

### rtl/tmfr_stats.sv
// Running total and the TRIM_EACH_SIDE smallest and largest periods of one scan.
`timescale 1ns / 1ps

module tmfr_stats import tmfr_pkg::*; (
  input  logic        clk,
  input  stats_ctrl_t ctrl,
  input  period_t     value,
  output stats_t      stats
);

  period_t          lo [TRIM_EACH_SIDE];
  period_t          hi [TRIM_EACH_SIDE];
  period_t          lo_up [TRIM_EACH_SIDE];
  period_t          hi_up [TRIM_EACH_SIDE];
  period_t          lo_next [TRIM_EACH_SIDE];
  period_t          hi_next [TRIM_EACH_SIDE];
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] lo_acc;
  logic [SUM_W-1:0] hi_acc;

  // Sorted insertion: lo ascending from the smallest, hi descending from the largest.
  always_comb begin
    lo_up[0] = value;
    hi_up[0] = value;
    for (int i = 1; i < TRIM_EACH_SIDE; i++) begin
      lo_up[i] = lo[i-1];
      hi_up[i] = hi[i-1];
    end
    for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
      if (value < lo[i]) begin
        lo_next[i] = (value < lo_up[i]) ? lo_up[i] : value;
      end else begin
        lo_next[i] = lo[i];
      end
      if (value > hi[i]) begin
        hi_next[i] = (value > hi_up[i]) ? hi_up[i] : value;
      end else begin
        hi_next[i] = hi[i];
      end
    end
  end

  always_comb begin
    lo_acc = '0;
    hi_acc = '0;
    for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
      lo_acc = lo_acc + SUM_W'(lo[i]);
      hi_acc = hi_acc + SUM_W'(hi[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
        lo[i] <= '1;
        hi[i] <= '0;
      end
      total <= '0;
    end else if (ctrl.take) begin
      lo    <= lo_next;
      hi    <= hi_next;
      total <= total + SUM_W'(value);
    end
  end

  assign stats.total  = total;
  assign stats.lo_sum = lo_acc;
  assign stats.hi_sum = hi_acc;

endmodule

### rtl/tmfr_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tmfr_div import tmfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] step;
  logic                 busy;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

### rtl/trimmed_mean_frame_rate_meter.sv
// Top level of the trimmed-mean frame rate meter: window chain, sequencer and rate ring.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    frame_period_us (24 bits)
// output    out_valid / out_ready  smooth_period_us (24 bits), frames_per_second (20 bits)
//
// The window scan (one cell per cycle around the chain) and the bit-serial dividers set
// the time from one acceptance to the next, with any stall of the final output load.
// Reset is synchronous and clears the window count, the rate ring and its slot pointer.
// A finished result waits in the output register while the next beat is accepted; only
// the final load of that register stalls when the previous result has not been taken.

module trimmed_mean_frame_rate_meter import tmfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PERIOD_W-1:0] frame_period_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PERIOD_W-1:0] smooth_period_us,
  output logic [RATE_W-1:0] frames_per_second
);

  state_t state;
  state_t state_next;

  // Control decoded by the sequencer.
  logic        in_accept;
  logic        chain_en;
  logic        div_start;
  logic        out_load;
  stats_ctrl_t stats_ctrl;

  // Window chain. A new period enters cell 0 and every cell passes its value up, so
  // the last cell drops the oldest period once the window is full. During the scan the
  // chain turns as a ring, the last cell feeding cell 0, and after one full turn
  // every period is back in place.
  period_t chain   [WINDOW_LEN];
  period_t chain_d [WINDOW_LEN];

  logic [CNT_W-1:0]  cnt;
  logic [SCAN_W-1:0] scan_idx;
  logic              scan_hit;

  stats_t            stats;
  logic              trim;
  logic [SUM_W-1:0]  kept_sum_c;
  logic [CNT_W-1:0]  kept_n_c;
  logic [SUM_W-1:0]  sum_kept;
  logic [CNT_W-1:0]  n_kept;

  logic [DIV_W-1:0]  rate_num;
  logic [DIV_W-1:0]  smooth_quo;
  logic [DIV_W-1:0]  rate_quo;
  logic              smooth_done;
  logic              rate_done;
  logic              div_done;
  logic [RATE_W-1:0] rate_now;

  logic [RATE_W-1:0]     ring [RATE_AVG_LEN];
  logic [SLOT_W-1:0]     slot;
  logic [RING_SUM_W-1:0] ring_total;
  logic [PROD_W-1:0]     prod;
  period_t               smooth_r;

  assign in_accept = in_valid && in_ready;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    chain_en        = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    stats_ctrl.clr  = 1'b0;
    stats_ctrl.take = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          chain_en       = 1'b1;
          stats_ctrl.clr = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        chain_en        = 1'b1;
        stats_ctrl.take = scan_hit;
        if (scan_idx == SCAN_W'(WINDOW_LEN - 1)) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        div_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_next = S_AVG;
        end
      end
      S_AVG: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Window chain of cells.
  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_d[g] = in_accept ? frame_period_us : chain[WINDOW_LEN-1];
    end else begin : g_body
      assign chain_d[g] = chain[g-1];
    end
    tmfr_cell u_cell (
      .clk (clk),
      .en  (chain_en),
      .d   (chain_d[g]),
      .q   (chain[g])
    );
  end

  // Only cells below the count hold periods. At scan step k the last cell shows what
  // cell WINDOW_LEN-1-k held before the scan, so it counts once k reaches
  // WINDOW_LEN - cnt.
  assign scan_hit = (state == S_SCAN) &&
                    (CNT_W'(scan_idx) >= (CNT_W'(WINDOW_LEN) - cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      scan_idx <= '0;
    end else begin
      if (in_accept) begin
        scan_idx <= '0;
        if (cnt != CNT_W'(WINDOW_LEN)) begin
          cnt <= cnt + 1'b1;
        end
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  tmfr_stats u_stats (
    .clk   (clk),
    .ctrl  (stats_ctrl),
    .value (chain[WINDOW_LEN-1]),
    .stats (stats)
  );

  // Trimming applies only when more than twice the trim depth is held; the kept sum is
  // then the total less the TRIM_EACH_SIDE smallest and largest periods.
  always_comb begin
    trim = cnt > CNT_W'(2 * TRIM_EACH_SIDE);
    if (trim) begin
      kept_sum_c = stats.total - stats.lo_sum - stats.hi_sum;
      kept_n_c   = cnt - CNT_W'(2 * TRIM_EACH_SIDE);
    end else begin
      kept_sum_c = stats.total;
      kept_n_c   = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      sum_kept <= kept_sum_c;
      n_kept   <= kept_n_c;
    end
  end

  // Two bit-serial dividers run side by side: sum / n for the smoothed period and
  // 1000000 * n / sum for the per-frame rate.
  assign rate_num = DIV_W'(RATE_NUM_W'(RATE_CAP) * RATE_NUM_W'(n_kept));

  tmfr_div u_div_smooth (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(sum_kept)),
    .divisor  (DIV_W'(n_kept)),
    .quotient (smooth_quo),
    .done     (smooth_done)
  );

  tmfr_div u_div_rate (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rate_num),
    .divisor  (DIV_W'(sum_kept)),
    .quotient (rate_quo),
    .done     (rate_done)
  );

  assign div_done = smooth_done && rate_done;

  // The rate saturates whenever the kept sum is below n, which also covers a zero sum
  // (n is never zero once a period has been pushed).
  assign rate_now = (SUM_W'(n_kept) > sum_kept) ? RATE_CAP : rate_quo[RATE_W-1:0];

  // Rate ring, cleared at reset, one slot written per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RATE_AVG_LEN; i++) begin
        ring[i] <= '0;
      end
      slot <= '0;
    end else if ((state == S_WAIT) && div_done) begin
      ring[slot] <= rate_now;
      if (slot == SLOT_W'(RATE_AVG_LEN - 1)) begin
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_comb begin
    ring_total = '0;
    for (int i = 0; i < RATE_AVG_LEN; i++) begin
      ring_total = ring_total + RING_SUM_W'(ring[i]);
    end
  end

  // The smoothed period is captured with the ring write; the ring mean is a multiply
  // by the reciprocal, registered before the shift.
  always_ff @(posedge clk) begin
    if ((state == S_WAIT) && div_done) begin
      smooth_r <= smooth_quo[PERIOD_W-1:0];
    end
    if (state == S_AVG) begin
      prod <= PROD_W'(ring_total) * PROD_W'(AVG_MUL);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      smooth_period_us  <= smooth_r;
      frames_per_second <= prod[AVG_SHIFT +: RATE_W];
    end
  end

endmodule

### rtl/tmfr_checker.sv
// Port-level checks of the trimmed-mean frame rate meter and their bind statement.
`timescale 1ns / 1ps

module tmfr_checker import tmfr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PERIOD_W-1:0] smooth_period_us,
  input logic [RATE_W-1:0]   frames_per_second
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smooth_period_us) &&
                                $stable(frames_per_second))
    else $error("output beat changed while stalled");

  // The reported rate is a mean of capped rates.
  a_rate_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frames_per_second <= RATE_CAP)
    else $error("frame rate above the cap");

  // Each beat starts a multi-cycle computation, so the input closes right after.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind trimmed_mean_frame_rate_meter tmfr_checker u_tmfr_checker (.*);
